// ===== src/aes256_pkg.sv =====
// Package: AES-256 types, S-box tables and GF(2^8) round helpers.
`default_nettype none
package aes256_pkg;

	localparam int NumRounds = 14;
	localparam int NumKeys = 15;
	localparam int NumWords = 60;
	localparam int RoundIdxW = 4;
	localparam int AddrW = 5;
	localparam int DefaultPipeStages = 28;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam logic [1:0] KEY_REG0 = 2'd0;
	localparam logic [1:0] KEY_REG1 = 2'd1;
	localparam logic [1:0] KEY_REG2 = 2'd2;
	localparam logic [1:0] KEY_REG3 = 2'd3;

	typedef logic [127:0] block_t;
	typedef logic [31:0] word_t;

	typedef struct packed {
		logic valid;
		logic dec;
	} ctl_t;

	typedef logic [7:0] byte_arr_t [256];

	localparam byte_arr_t FwdBox = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam byte_arr_t RevBox = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] rcon(input logic [2:0] idx);
		unique case (idx)
			3'd0: rcon = 8'h01;
			3'd1: rcon = 8'h02;
			3'd2: rcon = 8'h04;
			3'd3: rcon = 8'h08;
			3'd4: rcon = 8'h10;
			3'd5: rcon = 8'h20;
			3'd6: rcon = 8'h40;
			default: rcon = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] v);
		xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// byte k of state at bits [127-8k -: 8]; row k%4, col k/4
	function automatic block_t sub_shift(input block_t s, input logic inv);
		block_t o;
		int r, c, src, dst;
		o = '0;
		for (r = 0; r < 4; r++) begin
			for (c = 0; c < 4; c++) begin
				if (inv) begin
					src = 4 * c + r;
					dst = 4 * ((c + r) % 4) + r;
					o[127 - 8 * dst -: 8] = RevBox[s[127 - 8 * src -: 8]];
				end else begin
					src = 4 * ((c + r) % 4) + r;
					dst = 4 * c + r;
					o[127 - 8 * dst -: 8] = FwdBox[s[127 - 8 * src -: 8]];
				end
			end
		end
		return o;
	endfunction

	function automatic block_t mix_fwd(input block_t s);
		block_t o;
		logic [7:0] a0, a1, a2, a3;
		int c;
		o = '0;
		for (c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			o[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			o[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			o[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			o[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return o;
	endfunction

	// inverse mix = forward mix after the 04/05 pre-step
	function automatic block_t mix_inv(input block_t s);
		block_t p;
		logic [7:0] a0, a1, a2, a3, u, v;
		int c;
		p = '0;
		for (c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			u = xt(xt(a0 ^ a2));
			v = xt(xt(a1 ^ a3));
			p[127 - 32 * c -: 8] = a0 ^ u;
			p[119 - 32 * c -: 8] = a1 ^ v;
			p[111 - 32 * c -: 8] = a2 ^ u;
			p[103 - 32 * c -: 8] = a3 ^ v;
		end
		return mix_fwd(p);
	endfunction

	function automatic word_t sub_word(input word_t w);
		sub_word = {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
	endfunction

endpackage
`default_nettype wire

// ===== src/aes256_block_cipher.sv =====
// Top level: AES-256 ECB cipher, APB key port, unrolled round pipeline.
// Two register stages per round lie between start and done.
// Throughput: one block per cycle while busy is low; busy is high only while the key schedule runs.
// A key write reruns the schedule: a load step, then one word per cycle for words 8..59.
// Reset: key registers clear; the schedule of the all-zero key is rebuilt while busy is high.
// Results come out on done for one cycle each; the receiver cannot stall.
`default_nettype none
module aes256_block_cipher (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [aes256_pkg::AddrW-1:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input wire logic start,
	output logic busy,
	input wire logic opcode,
	input wire logic [63:0] block_hi,
	input wire logic [63:0] block_lo,
	output logic done,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);

	localparam int NK = aes256_pkg::NumKeys;
	localparam int NW = aes256_pkg::NumWords;
	localparam int PipeStages = aes256_pkg::DefaultPipeStages;

	logic [63:0] key_q [4];
	logic [31:0] w_q [NW];
	logic [5:0] kidx_q;
	logic kbusy_q;
	logic wr_en;
	logic [1:0] wr_idx;
	logic [31:0] t_word, new_word, prev_w;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign wr_idx = paddr[4:3];

	always_comb begin
		unique case (wr_idx)
			aes256_pkg::KEY_REG0: prdata = key_q[0];
			aes256_pkg::KEY_REG1: prdata = key_q[1];
			aes256_pkg::KEY_REG2: prdata = key_q[2];
			aes256_pkg::KEY_REG3: prdata = key_q[3];
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (wr_en) begin
			key_q[wr_idx] <= pwdata;
		end
	end

	// schedule: load step at index 7, then one word per cycle, words 8..59
	assign prev_w = w_q[kidx_q - 6'd1];
	assign ridx = 3'(kidx_q[5:3] - 3'd1);
	always_comb begin
		t_word = prev_w;
		if (kidx_q[2:0] == 3'd0)
			t_word = aes256_pkg::sub_word({prev_w[23:0], prev_w[31:24]})
				^ {aes256_pkg::rcon(ridx), 24'h0};
		else if (kidx_q[2:0] == 3'd4)
			t_word = aes256_pkg::sub_word(prev_w);
		new_word = w_q[kidx_q - 6'd8] ^ t_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbusy_q <= 1'b1;
			kidx_q <= 6'd7;
		end else if (wr_en) begin
			kbusy_q <= 1'b1;
			kidx_q <= 6'd7;
		end else if (kbusy_q) begin
			if (kidx_q == 6'(NW - 1)) kbusy_q <= 1'b0;
			else kidx_q <= kidx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (kbusy_q) begin
			if (kidx_q == 6'd7) begin
				for (int i = 0; i < 8; i++)
					w_q[i] <= key_q[i / 2][63 - 32 * (i % 2) -: 32];
			end else begin
				w_q[kidx_q] <= new_word;
			end
		end
	end

	assign busy = kbusy_q;

	aes256_pkg::block_t rk [NK];
	always_comb begin
		for (int r = 0; r < NK; r++)
			rk[r] = {w_q[4 * r], w_q[4 * r + 1], w_q[4 * r + 2], w_q[4 * r + 3]};
	end

	// stage pairs per round: A = sub/shift (+key for decrypt), B = mix (+key for encrypt); last B has no mix
	aes256_pkg::block_t st_s [PipeStages + 1];
	aes256_pkg::ctl_t ctl_s [PipeStages + 1];
	logic accept;
	aes256_pkg::block_t in_blk;

	assign accept = start && !busy;
	assign in_blk = {block_hi, block_lo};
	always_comb begin
		st_s[0] = in_blk ^ (opcode ? rk[NK - 1] : rk[0]);
		ctl_s[0] = '{valid: accept, dec: opcode};
	end

	for (genvar g = 0; g < PipeStages; g++) begin : g_stage
		localparam int Rnd = g / 2 + 1;
		aes256_pkg::block_t nxt;
		aes256_pkg::block_t sreg;
		aes256_pkg::ctl_t creg;
		always_comb begin
			if (g % 2 == 0) begin
				nxt = aes256_pkg::sub_shift(st_s[g], ctl_s[g].dec);
				if (ctl_s[g].dec) nxt = nxt ^ rk[NK - 1 - Rnd];
			end else if (Rnd == NK - 1) begin
				nxt = ctl_s[g].dec ? st_s[g] : st_s[g] ^ rk[Rnd];
			end else begin
				nxt = ctl_s[g].dec ? aes256_pkg::mix_inv(st_s[g])
					: aes256_pkg::mix_fwd(st_s[g]) ^ rk[Rnd];
			end
		end
		always_ff @(posedge clk) sreg <= nxt;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) creg <= '0;
			else creg <= ctl_s[g];
		end
		assign st_s[g + 1] = sreg;
		assign ctl_s[g + 1] = creg;
	end

	assign done = ctl_s[PipeStages].valid;
	assign result_hi = st_s[PipeStages][127:64];
	assign result_lo = st_s[PipeStages][63:0];

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ctl_s[0].valid) else $error("word taken while busy");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[1].valid |-> $past(accept)) else $error("stray stage valid");
	a_sched_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(kbusy_q) |-> $past(kidx_q) == 6'(NW - 1)) else $error("schedule cut short");
`endif

endmodule
`default_nettype wire
